@@ rtl/ppcc_pkg.sv @@
package ppcc_pkg;

	localparam int ROTATION_STEPS_DEF = 16;
	localparam int ANGLE_TABLE_LEN    = 24;
	localparam int STEP_IDX_W         = $clog2(ANGLE_TABLE_LEN);
	localparam int GUARD_BITS         = 8;
	localparam int VEC_W              = 42;
	localparam int ANG_W              = 33;
	localparam int PROD_W             = 63;
	localparam int GAIN_W             = 30;
	localparam int GAIN_SHIFT         = 30 - GUARD_BITS;
	localparam logic [GAIN_W-1:0] INV_GAIN_Q30 = 30'd652032874;

	typedef struct packed {
		logic signed [31:0] rel_x;
		logic signed [31:0] rel_y;
		logic signed [15:0] rel_heading;
		logic               first_in_chain;
	} item_t;

	typedef struct packed {
		logic signed [31:0] glob_x;
		logic signed [31:0] glob_y;
		logic signed [15:0] glob_heading;
		logic               saturated;
	} result_t;

	typedef struct packed {
		logic signed [VEC_W-1:0] x;
		logic signed [VEC_W-1:0] y;
		logic signed [ANG_W-1:0] z;
	} cordic_vec_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_X,
		ST_MUL_Y,
		ST_LOAD_Y,
		ST_ROTATE,
		ST_DONE
	} state_t;

	// atan(2^-i) with 2^32 units per turn.
	function automatic logic signed [ANG_W-1:0] atan_units(input logic [STEP_IDX_W-1:0] idx);
		logic [31:0] v;
		unique case (idx)
			5'd0:    v = 32'h20000000;
			5'd1:    v = 32'h12E4051E;
			5'd2:    v = 32'h09FB385B;
			5'd3:    v = 32'h051111D4;
			5'd4:    v = 32'h028B0D43;
			5'd5:    v = 32'h0145D7E1;
			5'd6:    v = 32'h00A2F61E;
			5'd7:    v = 32'h00517C55;
			5'd8:    v = 32'h0028BE53;
			5'd9:    v = 32'h00145F2F;
			5'd10:   v = 32'h000A2F98;
			5'd11:   v = 32'h000517CC;
			5'd12:   v = 32'h00028BE6;
			5'd13:   v = 32'h000145F3;
			5'd14:   v = 32'h0000A2FA;
			5'd15:   v = 32'h0000517D;
			5'd16:   v = 32'h000028BE;
			5'd17:   v = 32'h0000145F;
			5'd18:   v = 32'h00000A30;
			5'd19:   v = 32'h00000518;
			5'd20:   v = 32'h0000028C;
			5'd21:   v = 32'h00000146;
			5'd22:   v = 32'h000000A3;
			5'd23:   v = 32'h00000051;
			default: v = 32'h00000000;
		endcase
		return $signed({1'b0, v});
	endfunction

endpackage

@@ rtl/ppcc_cordic_step.sv @@
module ppcc_cordic_step
	import ppcc_pkg::*;
(
	input  cordic_vec_t            cur,
	input  logic [STEP_IDX_W-1:0]  idx,
	output cordic_vec_t            nxt
);

	logic signed [VEC_W-1:0] cx;
	logic signed [VEC_W-1:0] cy;
	logic signed [ANG_W-1:0] cz;
	logic signed [VEC_W-1:0] dx;
	logic signed [VEC_W-1:0] dy;
	logic signed [ANG_W-1:0] ang;

	always_comb begin
		cx  = cur.x;
		cy  = cur.y;
		cz  = cur.z;
		dx  = cy >>> idx;
		dy  = cx >>> idx;
		ang = atan_units(idx);
		// A non-negative residual angle rotates counterclockwise.
		if (!cz[ANG_W-1]) begin
			nxt.x = cx - dx;
			nxt.y = cy + dy;
			nxt.z = cz - ang;
		end else begin
			nxt.x = cx + dx;
			nxt.y = cy - dy;
			nxt.z = cz + ang;
		end
	end

endmodule

@@ rtl/planar_pose_chain_composer_top.sv @@
// Planar pose chain composer: each transaction on the item channel carries a pose relative to
// the last global pose; the block rotates the offset by the stored heading with a shared
// CORDIC step unit, adds the stored position with saturation, wraps the heading and returns
// one result per item. An item passes through idle, two states on the shared gain multiplier,
// a load state, one CORDIC iteration per rotation step and a final state for rounding and the
// final add before the next item is accepted. An item that starts a new chain goes from idle
// straight to the final state. A finished result waits in an output register, so the next
// item is accepted while it is still unclaimed. The final state of that next item holds for
// as long as the earlier result stays unclaimed.
module planar_pose_chain_composer_top
	import ppcc_pkg::*;
#(
	parameter int ROTATION_STEPS = ROTATION_STEPS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_ready,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	localparam int STEPS = (ROTATION_STEPS < ANGLE_TABLE_LEN) ? ROTATION_STEPS : ANGLE_TABLE_LEN;
	localparam logic [STEP_IDX_W-1:0] LAST_STEP = STEP_IDX_W'(STEPS - 1);

	state_t state_q;
	state_t state_d;

	logic signed [31:0]       rx_q;
	logic signed [31:0]       ry_q;
	logic signed [15:0]       rh_q;
	logic                     clear_q;
	logic                     neg_q;
	logic signed [PROD_W-1:0] prod_q;
	cordic_vec_t              vec_q;
	cordic_vec_t              vec_nxt;
	logic [STEP_IDX_W-1:0]    step_q;
	logic signed [31:0]       pose_x_q;
	logic signed [31:0]       pose_y_q;
	logic signed [15:0]       pose_heading_q;
	result_t                  result_q;
	logic                     result_valid_q;

	logic                     accept;
	logic                     result_load;
	logic                     mul_go;
	logic signed [31:0]       mul_a;
	logic signed [PROD_W-1:0] prod_d;
	logic signed [PROD_W-1:0] prod_shr;
	logic signed [VEC_W-1:0]  vfix;
	logic signed [VEC_W-1:0]  vload;
	logic                     h_neg;
	logic signed [15:0]       h_adj;
	logic signed [VEC_W-1:0]  x_rnd;
	logic signed [VEC_W-1:0]  y_rnd;
	logic signed [34:0]       x_sum;
	logic signed [34:0]       y_sum;
	logic signed [31:0]       x_sat;
	logic signed [31:0]       y_sat;
	logic                     x_clip;
	logic                     y_clip;
	result_t                  result_d;

	ppcc_cordic_step u_step (
		.cur (vec_q),
		.idx (step_q),
		.nxt (vec_nxt)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = item.first_in_chain ? ST_DONE : ST_MUL_X;
				end
			end
			ST_MUL_X:  state_d = ST_MUL_Y;
			ST_MUL_Y:  state_d = ST_LOAD_Y;
			ST_LOAD_Y: state_d = ST_ROTATE;
			ST_ROTATE: begin
				if (step_q == LAST_STEP) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (result_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		item_ready  = (state_q == ST_IDLE);
		mul_go      = (state_q == ST_MUL_X) || (state_q == ST_MUL_Y);
		result_load = (state_q == ST_DONE) && (!result_valid_q || result_ready);
	end

	assign accept = item_valid && item_ready;

	// Fold the stored heading into [-pi/2, pi/2] by negating the vector.
	always_comb begin
		h_neg = (pose_heading_q > 16'sd16384) || (pose_heading_q < -16'sd16384);
		h_adj = h_neg ? (pose_heading_q ^ 16'sh8000) : pose_heading_q;
	end

	assign mul_a    = (state_q == ST_MUL_X) ? rx_q : ry_q;
	assign prod_d   = mul_a * $signed({1'b0, INV_GAIN_Q30});
	assign prod_shr = prod_q >>> GAIN_SHIFT;
	assign vfix     = prod_shr[VEC_W-1:0];
	assign vload    = neg_q ? -vfix : vfix;

	// Round off the guard bits, add the stored position and clip; a chain start gives a zero result.
	always_comb begin
		x_rnd  = (vec_q.x + VEC_W'(signed'(1 <<< (GUARD_BITS - 1)))) >>> GUARD_BITS;
		y_rnd  = (vec_q.y + VEC_W'(signed'(1 <<< (GUARD_BITS - 1)))) >>> GUARD_BITS;
		x_sum  = $signed({x_rnd[33], x_rnd[33:0]}) + $signed({{3{pose_x_q[31]}}, pose_x_q});
		y_sum  = $signed({y_rnd[33], y_rnd[33:0]}) + $signed({{3{pose_y_q[31]}}, pose_y_q});
		x_clip = (x_sum[34:31] != {4{x_sum[34]}});
		y_clip = (y_sum[34:31] != {4{y_sum[34]}});
		x_sat  = x_clip ? (x_sum[34] ? 32'sh80000000 : 32'sh7FFFFFFF) : x_sum[31:0];
		y_sat  = y_clip ? (y_sum[34] ? 32'sh80000000 : 32'sh7FFFFFFF) : y_sum[31:0];
		if (clear_q) begin
			result_d = '0;
		end else begin
			result_d.glob_x       = x_sat;
			result_d.glob_y       = y_sat;
			result_d.glob_heading = pose_heading_q + rh_q;
			result_d.saturated    = x_clip || y_clip;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			result_valid_q <= 1'b0;
			pose_x_q       <= '0;
			pose_y_q       <= '0;
			pose_heading_q <= '0;
			step_q         <= '0;
		end else begin
			state_q <= state_d;
			if (result_load) begin
				result_valid_q <= 1'b1;
				pose_x_q       <= result_d.glob_x;
				pose_y_q       <= result_d.glob_y;
				pose_heading_q <= result_d.glob_heading;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
			if (state_q == ST_LOAD_Y) begin
				step_q <= '0;
			end else if (state_q == ST_ROTATE) begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rx_q    <= item.rel_x;
			ry_q    <= item.rel_y;
			rh_q    <= item.rel_heading;
			clear_q <= item.first_in_chain;
			neg_q   <= h_neg;
			vec_q.z <= $signed({h_adj[15], h_adj, 16'h0000});
		end
		if (mul_go) begin
			prod_q <= prod_d;
		end
		if (state_q == ST_MUL_Y) begin
			vec_q.x <= vload;
		end
		if (state_q == ST_LOAD_Y) begin
			vec_q.y <= vload;
		end
		if (state_q == ST_ROTATE) begin
			vec_q <= vec_nxt;
		end
		if (result_load) begin
			result_q <= result_d;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("item accepted while a previous item was still in work");

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ROTATE |-> step_q <= LAST_STEP)
		else $error("rotation step counter ran past the last step");

	a_sat_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.saturated |->
			result.glob_x == 32'sh7FFFFFFF || result.glob_x == 32'sh80000000 ||
			result.glob_y == 32'sh7FFFFFFF || result.glob_y == 32'sh80000000)
		else $error("saturated flag set without a coordinate at a range limit");

	a_chain_start: assert property (@(posedge clk) disable iff (!arst_n)
		result_load && clear_q |=>
			pose_x_q == 32'sd0 && pose_y_q == 32'sd0 && pose_heading_q == 16'sd0)
		else $error("start of chain did not return the pose to the origin");
`endif

endmodule
